FILE: hw/rtl/taylor_sine_cosine_unit_assert.svh
// Assertion macros for the sine / cosine unit checker.
// Used by tscu_checker; needs nothing else.
`ifndef TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH
`define TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define TSCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define TSCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset itself.
`define TSCU_ASSERT_AFTER(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tscu_pkg.sv
// Shared widths, constants and stage types of the sine / cosine unit.
// Depends on nothing; every other .sv file of the RTL uses it.
`timescale 1ns / 1ps

package tscu_pkg;

  // Port field widths.
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int THR_W   = 20;

  // Fixed-point layout: angles and terms are kept with 30 fraction bits.
  localparam int FRAC_W    = 30;
  localparam int ANG_SHIFT = 6;
  localparam int MAG_W     = ANGLE_W + ANG_SHIFT;
  localparam int RED_W     = MAG_W + 1;
  localparam int TWO_PI_W  = 33;
  localparam int AX_W      = 32;
  localparam int X2_W      = 34;
  localparam int TMAG_W    = 33;
  localparam int SUM_W     = 36;

  // Range reduction removes up to 31 turns, one binary digit per stage.
  localparam int RED_STEPS = 5;

  // Term divider: 40-bit dividend, 12-bit divisor, eight quotient bits a stage.
  localparam int DVD_W      = 40;
  localparam int DIV_W      = 12;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = DVD_W / DIV_STEPS;

  localparam logic [AX_W-1:0]     PI_Q30     = 32'd3373259426;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [TMAG_W-1:0]   ONE_Q30    = 33'd1073741824;

  localparam logic signed [SUM_W-1:0]   SUM_ONE         = 36'sd1073741824;
  localparam logic signed [SUM_W-1:0]   SUM_MINUS_ONE   = -36'sd1073741824;
  localparam logic signed [VALUE_W-1:0] VALUE_ONE       = 32'sd1073741824;
  localparam logic signed [VALUE_W-1:0] VALUE_MINUS_ONE = -32'sd1073741824;

  // Registered request as taken from the input port.
  typedef struct packed {
    logic              vld;
    logic              cos;
    logic              neg;
    logic [ANGLE_W-1:0] absv;
  } ang_t;

  // State handed from one term cell to the next.
  typedef struct packed {
    logic                     vld;
    logic                     cos;
    logic                     done;
    logic                     tneg;
    logic [TMAG_W-1:0]        tmag;
    logic signed [SUM_W-1:0]  sum;
    logic [X2_W-1:0]          x2;
  } term_t;

endpackage

FILE: hw/rtl/taylor_sine_cosine_unit.sv
// Sine / cosine of a Q8.24 angle by Taylor series, result in Q2.30. The unit
// is a fixed pipeline: an input stage, eight stages of range reduction,
// squaring and first term, then a row of MAX_TERMS-1 term cells of seven
// stages each (one multiply, five divider stages of eight quotient bits
// against the cell's constant divisor, one accumulate), then the output
// register. Every request passes through all stages, whatever the stop
// threshold, and one request can be taken every cycle unless the output
// stalls. When a result waits at the output,
// the whole pipeline holds; the input stage still takes a request if it is
// empty. The threshold register should only be written with the unit empty.
// Depends on tscu_pkg, tscu_front and tscu_cell.
`timescale 1ns / 1ps

module taylor_sine_cosine_unit #(
  parameter int MAX_TERMS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic                                 req_type,
  input  logic signed [tscu_pkg::ANGLE_W-1:0]  angle,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [tscu_pkg::VALUE_W-1:0]  value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tscu_pkg::THR_W-1:0]           term_threshold
);

  localparam int ANGLE_W = tscu_pkg::ANGLE_W;
  localparam int VALUE_W = tscu_pkg::VALUE_W;
  localparam int THR_W   = tscu_pkg::THR_W;
  localparam int N_CELLS = MAX_TERMS - 1;

  // Stop threshold register.
  logic [THR_W-1:0] thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr <= term_threshold;
    end
  end

  // The pipeline advances unless a result is stalled at the output.
  logic en;

  assign en = !res_valid || res_ready;

  // Input stage: sign and magnitude of the angle.
  logic [ANGLE_W-1:0] ang_u;
  logic [ANGLE_W-1:0] ang_abs;
  tscu_pkg::ang_t     ang_q;

  assign ang_u     = angle;
  assign ang_abs   = angle[ANGLE_W-1] ? (~ang_u + 1'b1) : ang_u;
  assign req_ready = en || !ang_q.vld;

  always_ff @(posedge clk) begin
    if (req_ready) begin
      ang_q.cos  <= req_type;
      ang_q.neg  <= angle[ANGLE_W-1];
      ang_q.absv <= ang_abs;
    end
    if (rst) begin
      ang_q.vld <= 1'b0;
    end else if (req_ready) begin
      ang_q.vld <= req_valid;
    end
  end

  // Range reduction and first term.
  wire tscu_pkg::term_t chain [N_CELLS+1];

  tscu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .thr  (thr),
    .ang  (ang_q),
    .term (chain[0])
  );

  // Row of term cells, one per further series term.
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    tscu_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .thr      (thr),
      .term_in  (chain[g]),
      .term_out (chain[g+1])
    );
  end

  // Output register with saturation to [-1, 1].
  logic signed [VALUE_W-1:0] value_next;

  always_comb begin
    if (chain[N_CELLS].sum > tscu_pkg::SUM_ONE) begin
      value_next = tscu_pkg::VALUE_ONE;
    end else if (chain[N_CELLS].sum < tscu_pkg::SUM_MINUS_ONE) begin
      value_next = tscu_pkg::VALUE_MINUS_ONE;
    end else begin
      value_next = chain[N_CELLS].sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= chain[N_CELLS].vld;
    end
  end

endmodule

FILE: hw/rtl/tscu_front.sv
// Front end of the sine / cosine unit: range reduction into [-pi, pi],
// squaring of the reduced angle and the first series term. Uses tscu_pkg.
`timescale 1ns / 1ps

module tscu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [tscu_pkg::THR_W-1:0]    thr,
  input  tscu_pkg::ang_t                ang,
  output tscu_pkg::term_t               term
);

  localparam int ANG_SHIFT = tscu_pkg::ANG_SHIFT;
  localparam int MAG_W     = tscu_pkg::MAG_W;
  localparam int RED_W     = tscu_pkg::RED_W;
  localparam int TWO_PI_W  = tscu_pkg::TWO_PI_W;
  localparam int AX_W      = tscu_pkg::AX_W;
  localparam int X2_W      = tscu_pkg::X2_W;
  localparam int TMAG_W    = tscu_pkg::TMAG_W;
  localparam int SUM_W     = tscu_pkg::SUM_W;
  localparam int FRAC_W    = tscu_pkg::FRAC_W;
  localparam int RED_STEPS = tscu_pkg::RED_STEPS;
  localparam int SQ_W      = 2 * AX_W + 1;
  localparam logic [SQ_W-1:0] SQ_HALF = SQ_W'(1) << (FRAC_W - 1);

  typedef struct packed {
    logic             vld;
    logic             cos;
    logic             neg;
    logic             at_pi;
    logic [RED_W-1:0] t;
  } red_t;

  typedef struct packed {
    logic            vld;
    logic            cos;
    logic            xneg;
    logic [AX_W-1:0] ax;
  } sq_t;

  wire red_t red_w [RED_STEPS+1];

  // Offset the magnitude by pi so that the remainder modulo two pi lands on [0, 2pi).
  logic [MAG_W-1:0] mag;
  red_t             red_b;
  red_t             red_q;

  always_comb begin
    mag         = {ang.absv, {ANG_SHIFT{1'b0}}};
    red_b.vld   = ang.vld;
    red_b.cos   = ang.cos;
    red_b.neg   = ang.neg;
    red_b.at_pi = (mag == MAG_W'(tscu_pkg::PI_Q30));
    red_b.t     = RED_W'(mag) + RED_W'(tscu_pkg::PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_q.vld <= 1'b0;
    end else if (en) begin
      red_q <= red_b;
    end
  end

  assign red_w[0] = red_q;

  // Restoring reduction: one multiple of two pi, largest first, per stage.
  for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
    localparam logic [RED_W-1:0] STEP_SUB =
      RED_W'(tscu_pkg::TWO_PI_Q30) << (RED_STEPS - 1 - g);
    red_t step_next;
    red_t step_q;

    always_comb begin
      step_next = red_w[g];
      if (red_w[g].t >= STEP_SUB) begin
        step_next.t = red_w[g].t - STEP_SUB;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        step_q.vld <= 1'b0;
      end else if (en) begin
        step_q <= step_next;
      end
    end

    assign red_w[g+1] = step_q;
  end

  // Remove the pi offset, take the magnitude and the sign of the reduced angle.
  logic [TWO_PI_W-1:0] rem;
  logic [TWO_PI_W-1:0] pi_ext;
  logic [TWO_PI_W-1:0] diff_hi;
  logic [TWO_PI_W-1:0] diff_lo;
  logic                gt_pi;
  logic                lt_pi;
  logic                at_pi;
  sq_t                 sq_next;
  sq_t                 sq_q;

  always_comb begin
    rem         = red_w[RED_STEPS].t[TWO_PI_W-1:0];
    pi_ext      = TWO_PI_W'(tscu_pkg::PI_Q30);
    at_pi       = red_w[RED_STEPS].at_pi;
    gt_pi       = rem > pi_ext;
    lt_pi       = rem < pi_ext;
    diff_hi     = rem - pi_ext;
    diff_lo     = pi_ext - rem;
    sq_next.vld = red_w[RED_STEPS].vld;
    sq_next.cos = red_w[RED_STEPS].cos;
    if (at_pi) begin
      sq_next.ax = tscu_pkg::PI_Q30;
    end else if (gt_pi) begin
      sq_next.ax = diff_hi[AX_W-1:0];
    end else begin
      sq_next.ax = diff_lo[AX_W-1:0];
    end
    if (red_w[RED_STEPS].neg) begin
      sq_next.xneg = at_pi || gt_pi;
    end else begin
      sq_next.xneg = !at_pi && lt_pi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_q.vld <= 1'b0;
    end else if (en) begin
      sq_q <= sq_next;
    end
  end

  // Square of the angle, rounded half up, and the first term of the series.
  logic [2*AX_W-1:0]  sq_prod;
  logic [SQ_W-1:0]    sq_rnd;
  logic [TMAG_W-1:0]  tmag0;
  logic               tneg0;
  logic [SUM_W-1:0]   sum_mag;
  tscu_pkg::term_t    term_next;

  always_comb begin
    sq_prod  = sq_q.ax * sq_q.ax;
    sq_rnd   = {1'b0, sq_prod} + SQ_HALF;
    tmag0    = sq_q.cos ? tscu_pkg::ONE_Q30 : TMAG_W'(sq_q.ax);
    tneg0    = sq_q.cos ? 1'b0 : sq_q.xneg;
    sum_mag  = SUM_W'(tmag0);
    term_next.vld  = sq_q.vld;
    term_next.cos  = sq_q.cos;
    term_next.tneg = tneg0;
    term_next.tmag = tmag0;
    term_next.sum  = tneg0 ? -$signed(sum_mag) : $signed(sum_mag);
    term_next.x2   = sq_rnd[X2_W+FRAC_W-1:FRAC_W];
    term_next.done = (tmag0 <= TMAG_W'(thr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term.vld <= 1'b0;
    end else if (en) begin
      term <= term_next;
    end
  end

endmodule

FILE: hw/rtl/tscu_cell.sv
// One term cell of the series chain: next term = term * x^2 / divisor,
// added into the running sum. Uses tscu_pkg.
`timescale 1ns / 1ps

module tscu_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [tscu_pkg::THR_W-1:0]  thr,
  input  tscu_pkg::term_t             term_in,
  output tscu_pkg::term_t             term_out
);

  localparam int TMAG_W     = tscu_pkg::TMAG_W;
  localparam int X2_W       = tscu_pkg::X2_W;
  localparam int SUM_W      = tscu_pkg::SUM_W;
  localparam int FRAC_W     = tscu_pkg::FRAC_W;
  localparam int DVD_W      = tscu_pkg::DVD_W;
  localparam int DIV_W      = tscu_pkg::DIV_W;
  localparam int DIV_STEPS  = tscu_pkg::DIV_STEPS;
  localparam int DIV_STAGES = tscu_pkg::DIV_STAGES;
  localparam int PROD_W     = TMAG_W + X2_W;
  localparam int RND_W      = PROD_W + 1;
  localparam int P_W        = RND_W - FRAC_W;

  // Divisors of this cell: (2i+2)(2i+3) for sine, (2i+1)(2i+2) for cosine.
  localparam int D_SIN_I = (2 * CELL_IDX + 2) * (2 * CELL_IDX + 3);
  localparam int D_COS_I = (2 * CELL_IDX + 1) * (2 * CELL_IDX + 2);
  localparam logic [DIV_W-1:0] D_SIN      = DIV_W'(D_SIN_I);
  localparam logic [DIV_W-1:0] D_COS      = DIV_W'(D_COS_I);
  localparam logic [DIV_W-1:0] D_SIN_HALF = DIV_W'(D_SIN_I / 2);
  localparam logic [DIV_W-1:0] D_COS_HALF = DIV_W'(D_COS_I / 2);
  localparam logic [RND_W-1:0] RND_HALF   = RND_W'(1) << (FRAC_W - 1);

  typedef struct packed {
    logic                     vld;
    logic                     cos;
    logic                     done;
    logic                     tneg;
    logic signed [SUM_W-1:0]  sum;
    logic [X2_W-1:0]          x2;
    logic [DIV_W-1:0]         rem;
    logic [DVD_W-1:0]         dvd;
  } div_t;

  wire div_t div_w [DIV_STAGES+1];

  // Multiply stage: term * x^2 in Q.30, rounded, plus half the divisor.
  logic [PROD_W-1:0] prod;
  logic [RND_W-1:0]  prod_rnd;
  logic [P_W-1:0]    prod_q30;
  div_t              mul_next;
  div_t              mul_q;

  always_comb begin
    prod          = term_in.tmag * term_in.x2;
    prod_rnd      = {1'b0, prod} + RND_HALF;
    prod_q30      = prod_rnd[RND_W-1:FRAC_W];
    mul_next.vld  = term_in.vld;
    mul_next.cos  = term_in.cos;
    mul_next.done = term_in.done;
    mul_next.tneg = term_in.tneg;
    mul_next.sum  = term_in.sum;
    mul_next.x2   = term_in.x2;
    mul_next.rem  = '0;
    mul_next.dvd  = DVD_W'(prod_q30) +
                    DVD_W'(term_in.cos ? D_COS_HALF : D_SIN_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_q.vld <= 1'b0;
    end else if (en) begin
      mul_q <= mul_next;
    end
  end

  assign div_w[0] = mul_q;

  // Long division by the constant divisor, eight quotient bits per stage.
  // Quotient bits shift into the dividend register as its bits are consumed.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [DIV_W-1:0] dsor;
    logic [DIV_W-1:0] rem_w;
    logic [DVD_W-1:0] dvd_w;
    logic [DIV_W:0]   trial;
    div_t             div_next;
    div_t             div_q;

    always_comb begin
      dsor  = div_w[s].cos ? D_COS : D_SIN;
      rem_w = div_w[s].rem;
      dvd_w = div_w[s].dvd;
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_w, dvd_w[DVD_W-1]};
        dvd_w = {dvd_w[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, dsor}) begin
          trial    = trial - {1'b0, dsor};
          dvd_w[0] = 1'b1;
        end
        rem_w = trial[DIV_W-1:0];
      end
      div_next     = div_w[s];
      div_next.rem = rem_w;
      div_next.dvd = dvd_w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_q.vld <= 1'b0;
      end else if (en) begin
        div_q <= div_next;
      end
    end

    assign div_w[s+1] = div_q;
  end

  // Accumulate stage: while not done, flip sign, add term, check stop level.
  logic [TMAG_W-1:0]        qmag;
  logic signed [SUM_W-1:0]  qterm;
  logic                     new_neg;
  tscu_pkg::term_t          term_next;

  always_comb begin
    qmag    = div_w[DIV_STAGES].dvd[TMAG_W-1:0];
    qterm   = $signed(SUM_W'(qmag));
    new_neg = !div_w[DIV_STAGES].tneg;
    term_next.vld  = div_w[DIV_STAGES].vld;
    term_next.cos  = div_w[DIV_STAGES].cos;
    term_next.x2   = div_w[DIV_STAGES].x2;
    term_next.tmag = qmag;
    if (div_w[DIV_STAGES].done) begin
      term_next.done = 1'b1;
      term_next.tneg = div_w[DIV_STAGES].tneg;
      term_next.sum  = div_w[DIV_STAGES].sum;
    end else begin
      term_next.done = (qmag <= TMAG_W'(thr));
      term_next.tneg = new_neg;
      term_next.sum  = new_neg ? (div_w[DIV_STAGES].sum - qterm)
                               : (div_w[DIV_STAGES].sum + qterm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_out.vld <= 1'b0;
    end else if (en) begin
      term_out <= term_next;
    end
  end

endmodule

FILE: hw/rtl/tscu_checker.sv
// Port-level checks for the sine / cosine unit, bound to its top level.
// Uses tscu_pkg and the assertion macros in taylor_sine_cosine_unit_assert.svh.
`timescale 1ns / 1ps
`include "taylor_sine_cosine_unit_assert.svh"

module tscu_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_ready,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic signed [tscu_pkg::VALUE_W-1:0]  value
);

  // A stalled result stays put.
  `TSCU_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(value), "result changed while stalled")

  // Results are saturated to plus or minus one.
  `TSCU_ASSERT_NOW(a_res_range, clk, rst, res_valid, value <= tscu_pkg::VALUE_ONE && value >= tscu_pkg::VALUE_MINUS_ONE, "result outside the unit range")

  // A free output always lets the pipeline take a new request.
  `TSCU_ASSERT_NOW(a_ready_link, clk, rst, res_ready, req_ready, "request blocked with the output free")

  // Reset empties the output.
  `TSCU_ASSERT_AFTER(a_reset_clear, clk, rst, !res_valid, "result valid after reset")

endmodule

bind taylor_sine_cosine_unit tscu_checker u_tscu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .value     (value)
);
